FILE: rtl/run_length_byte_encoder_assert.svh
// Assertion macros for the run-length byte encoder
`ifndef RUN_LENGTH_BYTE_ENCODER_ASSERT_SVH
`define RUN_LENGTH_BYTE_ENCODER_ASSERT_SVH

`ifndef ASSERT_OFF
`define RLBE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define RLBE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define RLBE_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define RLBE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/rlbe_pkg.sv
// Shared types and constants for the run-length byte encoder
`timescale 1ns / 1ps
package rlbe_pkg;

  localparam int TALLY_W  = 48;
  localparam int TOTAL_W  = 51;
  localparam int LEN_W    = 11;
  localparam int SYM_W    = 3;
  localparam int CODE_W   = 8;
  localparam int CHUNK_W  = 5;
  localparam int NUM_SYM  = 6;

  localparam logic [LEN_W-1:0]   MAX_INPUT_RUN = 11'd1953;
  localparam logic [CHUNK_W-1:0] CHUNK_MAX     = 5'd31;
  localparam logic [SYM_W-1:0]   NO_SYMBOL     = 3'd7;
  localparam logic [SYM_W-1:0]   FIRST_BAD_SYM = 3'd6;
  localparam logic [CODE_W-1:0]  END_MARK      = 8'd7;
  localparam logic [1:0]         SUM_LAST      = 2'd2;

  typedef logic [TALLY_W-1:0] tally_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_SPLIT,
    ST_SUM,
    ST_MARK
  } rlbe_state_t;

  typedef struct packed {
    logic load_item;
    logic merge;
    logic load_new;
    logic clear_pend;
    logic flush_emit;
    logic chunk_emit;
    logic out_last;
    logic sum_clear;
    logic sum_step;
    logic mark_emit;
  } rlbe_cmd_t;

  typedef struct packed {
    logic kind;
    logic sym_bad;
    logic same_sym;
    logic pend_emit;
    logic merged_long;
    logic item_long;
    logic pend_long2;
    logic sum_done;
    logic slot_free;
  } rlbe_status_t;

endpackage

FILE: rtl/run_length_byte_encoder.sv
// Top level of the run-length byte encoder
//
// Input channel (in_valid/in_ready) carries one item per transfer: a run
// (kind 0, symbol 0..5, run_length) or a finish request (kind 1).
// Output channel (out_valid/out_ready) carries code bytes, length in bits
// 7..3 and symbol in bits 2..0, with six running tallies; byte 7 is the end
// marker, which also carries grand_total and closes the stream.
// Runs of the same symbol merge into one pending run; a pending run above 31
// is cut into 31-symbol bytes and the rest stays pending; last marks the
// final byte of an item. An item passes IDLE and FLUSH in the control
// sequencer; each split chunk of a long run adds a SPLIT step, which waits
// on the single output register. The first byte of an item is loaded into
// the output register from FLUSH, or from SPLIT when a long run starts with
// nothing to flush. A finish passes flush, a 3-step tally adder and the
// marker, which is loaded into the output register from MARK.
// Reset clears the pending run and the tallies at once; no clearing pass.
// A stalled receiver holds the output register; the sequencer waits on it
// and in_ready stays low until the current item is fully issued.
`timescale 1ns / 1ps
`include "run_length_byte_encoder_assert.svh"
module run_length_byte_encoder
  import rlbe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [SYM_W-1:0]   symbol,
  input  logic [LEN_W-1:0]   run_length,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CODE_W-1:0]  code_byte,
  output logic               last,
  output tally_t             tally_zero,
  output tally_t             tally_one,
  output tally_t             tally_two,
  output tally_t             tally_three,
  output tally_t             tally_four,
  output tally_t             tally_five,
  output logic [TOTAL_W-1:0] grand_total
);

  rlbe_cmd_t    cmd;
  rlbe_status_t status;
  tally_t       out_tally [NUM_SYM];

  rlbe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rlbe_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .kind        (kind),
    .symbol      (symbol),
    .run_length  (run_length),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .code_byte   (code_byte),
    .last        (last),
    .out_tally   (out_tally),
    .grand_total (grand_total)
  );

  assign tally_zero  = out_tally[0];
  assign tally_one   = out_tally[1];
  assign tally_two   = out_tally[2];
  assign tally_three = out_tally[3];
  assign tally_four  = out_tally[4];
  assign tally_five  = out_tally[5];

  `RLBE_ASSERT_IMPLY(a_mark_is_last, clk, rst, out_valid && code_byte == END_MARK, last)
  `RLBE_ASSERT_IMPLY(a_total_only_on_mark, clk, rst, out_valid && code_byte != END_MARK, grand_total == '0)
  `RLBE_ASSERT_IMPLY(a_byte_has_length, clk, rst, out_valid, code_byte[7:3] != '0 || code_byte == END_MARK)
  `RLBE_ASSERT_NEXT(a_busy_after_transfer, clk, rst, in_valid && in_ready, !in_ready)

endmodule

FILE: rtl/rlbe_ctrl.sv
// Control state machine for the run-length byte encoder
`timescale 1ns / 1ps
module rlbe_ctrl
  import rlbe_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  rlbe_status_t status,
  output rlbe_cmd_t    cmd
);

  rlbe_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (status.kind) begin
          if (!status.pend_emit || status.slot_free) begin
            cmd.flush_emit = status.pend_emit;
            cmd.clear_pend = 1'b1;
            cmd.sum_clear  = 1'b1;
            state_next     = ST_SUM;
          end
        end else if (status.sym_bad) begin
          state_next = ST_IDLE;
        end else if (status.same_sym) begin
          cmd.merge  = 1'b1;
          state_next = status.merged_long ? ST_SPLIT : ST_IDLE;
        end else if (!status.pend_emit || status.slot_free) begin
          cmd.flush_emit = status.pend_emit;
          cmd.out_last   = !status.item_long;
          cmd.load_new   = 1'b1;
          state_next     = status.item_long ? ST_SPLIT : ST_IDLE;
        end
      end
      ST_SPLIT: begin
        if (status.slot_free) begin
          cmd.chunk_emit = 1'b1;
          cmd.out_last   = !status.pend_long2;
          state_next     = status.pend_long2 ? ST_SPLIT : ST_IDLE;
        end
      end
      ST_SUM: begin
        cmd.sum_step = 1'b1;
        if (status.sum_done) begin
          state_next = ST_MARK;
        end
      end
      ST_MARK: begin
        if (status.slot_free) begin
          cmd.mark_emit = 1'b1;
          cmd.out_last  = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/rlbe_datapath.sv
// Pending run, tallies, total adder and output register of the run-length byte encoder
`timescale 1ns / 1ps
module rlbe_datapath
  import rlbe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               kind,
  input  logic [SYM_W-1:0]   symbol,
  input  logic [LEN_W-1:0]   run_length,
  input  logic               out_ready,
  input  rlbe_cmd_t          cmd,
  output rlbe_status_t       status,
  output logic               out_valid,
  output logic [CODE_W-1:0]  code_byte,
  output logic               last,
  output tally_t             out_tally [NUM_SYM],
  output logic [TOTAL_W-1:0] grand_total
);

  logic               item_kind;
  logic [SYM_W-1:0]   item_sym;
  logic [LEN_W-1:0]   item_len;
  logic [SYM_W-1:0]   pend_sym;
  logic [LEN_W-1:0]   pend_len;
  logic [LEN_W-1:0]   merged_len;
  tally_t             tally      [NUM_SYM];
  tally_t             tally_next [NUM_SYM];
  logic [TALLY_W:0]   pair_sum   [3];
  logic [TOTAL_W-1:0] total;
  logic [1:0]         sum_phase;
  logic               emit;
  logic [CHUNK_W-1:0] emit_len;

  assign merged_len = pend_len + item_len;
  assign emit       = cmd.flush_emit | cmd.chunk_emit;
  assign emit_len   = cmd.chunk_emit ? CHUNK_MAX : pend_len[CHUNK_W-1:0];

  always_comb begin
    status.kind        = item_kind;
    status.sym_bad     = item_sym >= FIRST_BAD_SYM;
    status.same_sym    = item_sym == pend_sym;
    status.pend_emit   = (pend_sym < FIRST_BAD_SYM) && (pend_len != '0);
    status.merged_long = merged_len > LEN_W'(CHUNK_MAX);
    status.item_long   = item_len > LEN_W'(CHUNK_MAX);
    status.pend_long2  = pend_len > (LEN_W'(CHUNK_MAX) + LEN_W'(CHUNK_MAX));
    status.sum_done    = sum_phase == SUM_LAST;
    status.slot_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_kind <= kind;
      item_sym  <= symbol;
      item_len  <= (run_length > MAX_INPUT_RUN) ? MAX_INPUT_RUN : run_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_sym <= NO_SYMBOL;
      pend_len <= '0;
    end else if (cmd.clear_pend || cmd.mark_emit) begin
      pend_sym <= NO_SYMBOL;
      pend_len <= '0;
    end else if (cmd.load_new) begin
      pend_sym <= item_sym;
      pend_len <= item_len;
    end else if (cmd.merge) begin
      pend_len <= merged_len;
    end else if (cmd.chunk_emit) begin
      pend_len <= pend_len - LEN_W'(CHUNK_MAX);
    end
  end

  for (genvar i = 0; i < NUM_SYM; i++) begin : g_lane
    logic [TALLY_W:0] lane_sum;
    assign lane_sum = {1'b0, tally[i]} + (TALLY_W + 1)'(emit_len);
    always_comb begin
      tally_next[i] = tally[i];
      if (emit && (pend_sym == SYM_W'(i))) begin
        tally_next[i] = lane_sum[TALLY_W] ? '1 : lane_sum[TALLY_W-1:0];
      end
    end
    always_ff @(posedge clk) begin
      if (rst || cmd.mark_emit) begin
        tally[i] <= '0;
      end else begin
        tally[i] <= tally_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_phase <= '0;
    end else if (cmd.sum_clear) begin
      sum_phase <= '0;
    end else if (cmd.sum_step) begin
      sum_phase <= sum_phase + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_step) begin
      case (sum_phase)
        2'd0: begin
          pair_sum[0] <= {1'b0, tally[0]} + {1'b0, tally[1]};
          pair_sum[1] <= {1'b0, tally[2]} + {1'b0, tally[3]};
          pair_sum[2] <= {1'b0, tally[4]} + {1'b0, tally[5]};
        end
        2'd1: begin
          total <= {2'b0, pair_sum[0]} + {2'b0, pair_sum[1]};
        end
        default: begin
          total <= total + {2'b0, pair_sum[2]};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit || cmd.mark_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      code_byte   <= {emit_len, pend_sym};
      last        <= cmd.out_last;
      out_tally   <= tally_next;
      grand_total <= '0;
    end else if (cmd.mark_emit) begin
      code_byte   <= END_MARK;
      last        <= cmd.out_last;
      out_tally   <= tally;
      grand_total <= total;
    end
  end

endmodule
